/* rtl/mlfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlfr_pkg;

    // Action codes of an input item
    localparam logic [2:0] ACT_PIXEL    = 3'd0;
    localparam logic [2:0] ACT_FILL     = 3'd1;
    localparam logic [2:0] ACT_CONTRAST = 3'd2;
    localparam logic [2:0] ACT_REFRESH  = 3'd3;
    localparam logic [2:0] ACT_TICK     = 3'd4;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Panel command bytes
    localparam logic [7:0] CMD_VOLUME   = 8'h81;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW  = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] CMD_RMW      = 8'hE0;
    localparam logic [7:0] BYTE_BLACK   = 8'h00;
    localparam logic [7:0] BYTE_WHITE   = 8'hFF;

    localparam int          HEAD_STEPS = 4;
    localparam logic [7:0]  PCT_MAX    = 8'd100;
    // pct * 63 / 100 == (pct * VOL_RECIP) >> VOL_SHIFT for pct in 0..100
    localparam logic [18:0] VOL_RECIP  = 19'd330309;
    localparam int          VOL_SHIFT  = 19;

    // Stream step counter and effective width: up to 4 + 255 steps
    localparam int STEP_W = 9;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SEL_STATUS = 2'd0,
        SEL_VOL0   = 2'd1,
        SEL_VOL1   = 2'd2,
        SEL_STREAM = 2'd3
    } t_emit_sel;

    typedef struct packed {
        logic      in_ready;
        logic      load;
        logic      sweep_wr;
        logic      sweep_fill;
        logic      pix_rd;
        logic      pix_wr;
        logic      tick_rd;
        logic      calc;
        logic      arm;
        logic      emit;
        t_emit_sel sel;
        t_status   code;
    } t_cmd;

    typedef struct packed {
        logic [2:0] act;
        logic       active;
        logic       pix_oor;
        logic       sweep_last;
        logic       out_free;
        logic       stream_last;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/mlfr_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mlfr_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] col_x;
    logic [7:0] row_y;
    logic       pixel_on;
    logic [7:0] contrast_pct;

    modport source (output valid, action, col_x, row_y, pixel_on, contrast_pct,
                    input ready);
    modport sink   (input valid, action, col_x, row_y, pixel_on, contrast_pct,
                    output ready);
endinterface

`default_nettype wire

/* rtl/mlfr_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface mlfr_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [1:0] status_code;
    logic [7:0] link_byte;
    logic       is_command;
    logic       last_byte;

    modport source (output valid, out_kind, status_code, link_byte, is_command, last_byte,
                    input ready);
    modport sink   (input valid, out_kind, status_code, link_byte, is_command, last_byte,
                    output ready);
endinterface

`default_nettype wire

/* rtl/mlfr_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlfr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/mlfr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlfr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire mlfr_pkg::t_sts i_sts,
    output mlfr_pkg::t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECODE = 6'b000100,
        S_RMW    = 6'b001000,
        S_FILL   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    mlfr_pkg::t_emit_sel r_sel, n_sel;
    mlfr_pkg::t_status   r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sel   <= mlfr_pkg::SEL_STATUS;
            r_code  <= mlfr_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_code  <= n_code;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.sel  = r_sel;
        o_cmd.code = r_code;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_sel  = mlfr_pkg::SEL_STATUS;
                n_code = mlfr_pkg::ST_OK;
                if (i_sts.act == mlfr_pkg::ACT_TICK) begin
                    if (i_sts.active) begin
                        o_cmd.tick_rd = 1'b1;
                        n_sel   = mlfr_pkg::SEL_STREAM;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_sts.act > mlfr_pkg::ACT_TICK) begin
                    n_state = S_IDLE;
                end else if (i_sts.active) begin
                    n_code  = mlfr_pkg::ST_BUSY;
                    n_state = S_EMIT;
                end else begin
                    case (i_sts.act)
                        mlfr_pkg::ACT_PIXEL: begin
                            if (i_sts.pix_oor) begin
                                n_code  = mlfr_pkg::ST_RANGE;
                                n_state = S_EMIT;
                            end else begin
                                o_cmd.pix_rd = 1'b1;
                                n_state = S_RMW;
                            end
                        end
                        mlfr_pkg::ACT_FILL: begin
                            n_state = S_FILL;
                        end
                        mlfr_pkg::ACT_CONTRAST: begin
                            o_cmd.calc = 1'b1;
                            n_sel   = mlfr_pkg::SEL_VOL0;
                            n_state = S_EMIT;
                        end
                        default: begin
                            o_cmd.arm = 1'b1;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_RMW: begin
                o_cmd.pix_wr = 1'b1;
                n_state = S_EMIT;
            end
            S_FILL: begin
                o_cmd.sweep_wr   = 1'b1;
                o_cmd.sweep_fill = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_sel == mlfr_pkg::SEL_VOL0) begin
                        n_sel = mlfr_pkg::SEL_VOL1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/mlfr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlfr_datapath #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mlfr_pkg::t_cmd i_cmd,
    output mlfr_pkg::t_sts      o_sts,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_idx,
    input  wire logic [7:0]     i_cfg_data,
    input  wire logic [2:0]     i_action,
    input  wire logic [7:0]     i_col_x,
    input  wire logic [7:0]     i_row_y,
    input  wire logic           i_pixel_on,
    input  wire logic [7:0]     i_contrast_pct,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic                o_out_kind,
    output logic [1:0]          o_status_code,
    output logic [7:0]          o_link_byte,
    output logic                o_is_command,
    output logic                o_last_byte
);

    localparam int CB    = $clog2(COLUMNS);
    localparam int DEPTH = PAGES * (1 << CB);
    localparam int AW    = $clog2(DEPTH);
    localparam int PCW   = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SW    = mlfr_pkg::STEP_W;

    // Item fields and configuration
    logic [2:0] r_act;
    logic [7:0] r_x, r_y, r_pct;
    logic       r_on;
    logic [7:0] r_width;
    logic [6:0] r_height;

    // Stream state
    logic           r_active, n_active;
    logic [PCW-1:0] r_page, n_page;
    logic [SW-1:0]  r_step, n_step;
    logic [AW-1:0]  r_sweep;
    logic [5:0]     r_scaled;

    // Output register
    logic       r_o_valid;
    logic       r_o_kind, r_o_cmd, r_o_last;
    logic [1:0] r_o_code;
    logic [7:0] r_o_byte;

    logic [SW-1:0]  w_eff;
    logic [SW-1:0]  w_step_inc;
    logic           w_page_end, w_last_page;
    logic [SW-1:0]  w_col;
    logic [AW-1:0]  w_pix_addr, w_stream_addr;
    logic [7:0]     w_rdata, w_mask, w_mod, w_fill;
    logic           w_we, w_re;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [7:0]     w_wdata;
    logic [6:0]     w_clamp;
    logic [25:0]    w_prod;
    logic [3:0]     w_page_cmd;
    logic [7:0]     w_head_byte;
    logic           w_in_head;

    assign w_eff = (SW'(r_width) < SW'(COLUMNS)) ? SW'(r_width) : SW'(COLUMNS);
    assign w_step_inc  = r_step + SW'(1);
    assign w_page_end  = ({1'b0, w_step_inc} >= ((SW + 1)'(mlfr_pkg::HEAD_STEPS)
                         + {1'b0, w_eff}));
    assign w_last_page = (r_page == PCW'(PAGES - 1));
    assign w_col       = r_step - SW'(mlfr_pkg::HEAD_STEPS);
    assign w_in_head   = (r_step < SW'(mlfr_pkg::HEAD_STEPS));

    assign w_pix_addr    = AW'({r_y[7:3], r_x[CB-1:0]});
    assign w_stream_addr = AW'({r_page, w_col[CB-1:0]});

    assign w_mask = 8'h80 >> r_y[2:0];
    assign w_mod  = r_on ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
    assign w_fill = (i_cmd.sweep_fill && !r_on) ? mlfr_pkg::BYTE_WHITE : mlfr_pkg::BYTE_BLACK;

    assign w_we    = i_cmd.sweep_wr | i_cmd.pix_wr;
    assign w_waddr = i_cmd.sweep_wr ? r_sweep : w_pix_addr;
    assign w_wdata = i_cmd.sweep_wr ? w_fill : w_mod;
    assign w_re    = i_cmd.pix_rd | i_cmd.tick_rd;
    assign w_raddr = i_cmd.pix_rd ? w_pix_addr : w_stream_addr;

    mlfr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_clamp = (r_pct > mlfr_pkg::PCT_MAX) ? 7'(mlfr_pkg::PCT_MAX) : r_pct[6:0];
    assign w_prod  = 26'(w_clamp) * 26'(mlfr_pkg::VOL_RECIP);

    assign w_page_cmd = 4'(PAGES - 1) - 4'(r_page);
    always_comb begin
        case (r_step[1:0])
            2'd0:    w_head_byte = mlfr_pkg::CMD_PAGE | {4'd0, w_page_cmd};
            2'd1:    w_head_byte = mlfr_pkg::CMD_COL_LOW;
            2'd2:    w_head_byte = mlfr_pkg::CMD_COL_HIGH;
            default: w_head_byte = mlfr_pkg::CMD_RMW;
        endcase
    end

    // Stream counters: restart on arm, advance on each stream byte, wrap per page
    always_comb begin
        n_active = r_active;
        n_page   = r_page;
        n_step   = r_step;
        if (i_cmd.arm) begin
            n_active = 1'b1;
            n_page   = '0;
            n_step   = '0;
        end else if (i_cmd.emit && i_cmd.sel == mlfr_pkg::SEL_STREAM) begin
            n_step = w_step_inc;
            if (w_page_end) begin
                n_step = '0;
                if (w_last_page) begin
                    n_page   = '0;
                    n_active = 1'b0;
                end else begin
                    n_page = r_page + PCW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 8'd128;
            r_height  <= 7'd64;
            r_active  <= 1'b0;
            r_page    <= '0;
            r_step    <= '0;
            r_sweep   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mlfr_pkg::CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data[6:0];
                end
            end
            r_active <= n_active;
            r_page   <= n_page;
            r_step   <= n_step;
            if (i_cmd.sweep_wr) begin
                r_sweep <= (r_sweep == AW'(DEPTH - 1)) ? '0 : r_sweep + AW'(1);
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_x   <= i_col_x;
            r_y   <= i_row_y;
            r_on  <= i_pixel_on;
            r_pct <= i_contrast_pct;
        end
        if (i_cmd.calc) begin
            r_scaled <= w_prod[mlfr_pkg::VOL_SHIFT +: 6];
        end
        if (i_cmd.emit) begin
            r_o_kind <= 1'b1;
            r_o_code <= mlfr_pkg::ST_OK;
            r_o_byte <= 8'd0;
            r_o_cmd  <= 1'b1;
            r_o_last <= 1'b0;
            case (i_cmd.sel)
                mlfr_pkg::SEL_STATUS: begin
                    r_o_kind <= 1'b0;
                    r_o_code <= i_cmd.code;
                    r_o_cmd  <= 1'b0;
                end
                mlfr_pkg::SEL_VOL0: begin
                    r_o_byte <= mlfr_pkg::CMD_VOLUME;
                end
                mlfr_pkg::SEL_VOL1: begin
                    r_o_byte <= {2'b00, r_scaled};
                    r_o_last <= 1'b1;
                end
                default: begin
                    r_o_byte <= w_in_head ? w_head_byte : w_rdata;
                    r_o_cmd  <= w_in_head;
                    r_o_last <= w_page_end && w_last_page;
                end
            endcase
        end
    end

    assign o_sts.act         = r_act;
    assign o_sts.active      = r_active;
    assign o_sts.pix_oor     = (SW'(r_x) >= w_eff) || (r_y >= {1'b0, r_height})
                               || (r_y[7:3] >= 5'(PAGES));
    assign o_sts.sweep_last  = (r_sweep == AW'(DEPTH - 1));
    assign o_sts.out_free    = !r_o_valid || i_ready;
    assign o_sts.stream_last = w_page_end && w_last_page;

    assign o_valid       = r_o_valid;
    assign o_out_kind    = r_o_kind;
    assign o_status_code = r_o_code;
    assign o_link_byte   = r_o_byte;
    assign o_is_command  = r_o_cmd;
    assign o_last_byte   = r_o_last;

endmodule

`default_nettype wire

/* rtl/mono_lcd_framebuffer_refresher_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// A pixel write goes from input transfer through the decode, read-modify-write and emit
// states to the output register; tick / set contrast / start refresh / busy go through
// decode and emit (contrast adds an emit for its second byte). Throughput: one item at a time;
// fill holds the input while it sweeps the single write port of the frame store.
// Reset (synchronous, active low) clears control, then runs a clearing pass over every
// word of the frame store; no input is taken until it ends.

module mono_lcd_framebuffer_refresher_unit #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mlfr_in_if.sink         i_in,
    mlfr_out_if.source      o_out,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    // Command and status between the sequencer and the datapath
    mlfr_pkg::t_cmd w_cmd;
    mlfr_pkg::t_sts w_sts;

    // Sequencer: decodes each item, runs the store sweeps and read-modify-write,
    // and hands every result to the output register one transfer at a time.
    mlfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_cmd.in_ready;

    // Datapath: frame store, stream counters, contrast scaling, output register
    mlfr_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_action       (i_in.action),
        .i_col_x        (i_in.col_x),
        .i_row_y        (i_in.row_y),
        .i_pixel_on     (i_in.pixel_on),
        .i_contrast_pct (i_in.contrast_pct),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_out_kind     (o_out.out_kind),
        .o_status_code  (o_out.status_code),
        .o_link_byte    (o_out.link_byte),
        .o_is_command   (o_out.is_command),
        .o_last_byte    (o_out.last_byte)
    );

    // Never load the output register while it still holds an untaken result
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("result loaded over a pending transfer");

    // Stream bytes only while a refresh is armed
    a_stream_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.sel == mlfr_pkg::SEL_STREAM) |-> w_sts.active)
        else $error("stream byte without active refresh");

    // The final stream byte drops the refresh
    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.sel == mlfr_pkg::SEL_STREAM && w_sts.stream_last)
        |=> !w_sts.active)
        else $error("refresh still active after last byte");

    // No store write or output load while the input side is open
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.in_ready |-> !(w_cmd.sweep_wr || w_cmd.pix_wr || w_cmd.emit))
        else $error("store or output activity while idle");

endmodule

`default_nettype wire

/* tb/tb_mono_lcd_framebuffer_refresher_unit.sv */
`timescale 1ns / 1ps

module tb_mono_lcd_framebuffer_refresher_unit;

    localparam int COLS       = 128;
    localparam int PAGES_N    = 8;
    localparam int VOL_FULL   = 63;      // contrast scale at 100 percent
    localparam int IDLE_PCT   = 20;      // idle share of each side, in percent
    localparam int SETTLE_CYC = 1100;    // covers a fill sweep still in flight
    localparam int TAIL_CYC   = 64;
    localparam int WDOG_LIMIT = 20000;   // cycles without any transfer
    localparam int STALL_AT   = 150;     // result count that starts the long stall
    localparam int STALL_CYC  = 400;

    // Action codes the block ignores
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] col_x;
        logic [7:0] row_y;
        logic       pixel_on;
        logic [7:0] contrast_pct;
    } t_lcd_op;

    typedef struct packed {
        logic       out_kind;
        logic [1:0] status_code;
        logic [7:0] link_byte;
        logic       is_command;
        logic       last_byte;
    } t_lcd_out;

    logic i_clk;
    logic i_rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [7:0] cfg_data;

    mlfr_in_if  in_bus ();
    mlfr_out_if out_bus ();

    mono_lcd_framebuffer_refresher_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Ops waiting to be sent, and panel outputs still owed by the block
    t_lcd_op  op_q[$];
    t_lcd_out due_q[$];

    // Shadow of the frame store, the stream position and the panel size
    logic [7:0]  shadow_fb [0:PAGES_N*COLS-1];
    logic        scan_on;
    int unsigned scan_page;
    int unsigned scan_step;
    logic [7:0]  cfg_width;
    logic [6:0]  cfg_height;

    t_lcd_op  driven_op;
    t_lcd_out got_out;
    t_lcd_out want_out;
    bit       calm;          // no idling on either side while set
    int       err_count;
    int       outs_seen;
    int       stall_left;
    int       wdog_cnt;

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Expected outputs
    // ------------------------------------------------------------------
    function automatic void owe_status(input mlfr_pkg::t_status code);
        t_lcd_out r;
        r = '0;
        r.status_code = code;
        due_q.push_back(r);
    endfunction

    function automatic void owe_link(input logic [7:0] b, input logic cmd, input logic lst);
        t_lcd_out r;
        r = '0;
        r.out_kind   = 1'b1;
        r.link_byte  = b;
        r.is_command = cmd;
        r.last_byte  = lst;
        due_q.push_back(r);
    endfunction

    // Advance the shadow by one accepted op and queue what the block owes for it
    function automatic void apply_lcd_op(input t_lcd_op op);
        int unsigned w;
        int unsigned page;
        int unsigned idx;
        int          c;
        logic [7:0]  b;
        logic [7:0]  mask;
        logic        cmd;
        logic        lst;
        w = (cfg_width < COLS) ? cfg_width : COLS;
        if (op.action > mlfr_pkg::ACT_TICK)
            return;
        if (op.action == mlfr_pkg::ACT_TICK) begin
            if (!scan_on)
                return;
            if (scan_step < mlfr_pkg::HEAD_STEPS) begin
                cmd = 1'b1;
                case (scan_step)
                    0: b = mlfr_pkg::CMD_PAGE | (8'(PAGES_N - 1 - scan_page) & 8'h0F);
                    1: b = mlfr_pkg::CMD_COL_LOW;
                    2: b = mlfr_pkg::CMD_COL_HIGH;
                    default: b = mlfr_pkg::CMD_RMW;
                endcase
            end else begin
                cmd = 1'b0;
                b = shadow_fb[scan_page * COLS + scan_step - mlfr_pkg::HEAD_STEPS];
            end
            lst = 1'b0;
            scan_step++;
            if (scan_step >= mlfr_pkg::HEAD_STEPS + w) begin
                scan_step = 0;
                scan_page++;
                if (scan_page >= PAGES_N) begin
                    scan_page = 0;
                    scan_on   = 1'b0;
                    lst       = 1'b1;
                end
            end
            owe_link(b, cmd, lst);
            return;
        end
        if (scan_on) begin
            owe_status(mlfr_pkg::ST_BUSY);
            return;
        end
        case (op.action)
            mlfr_pkg::ACT_PIXEL: begin
                page = op.row_y >> 3;
                if (op.col_x >= w || op.row_y >= cfg_height || page >= PAGES_N) begin
                    owe_status(mlfr_pkg::ST_RANGE);
                end else begin
                    idx  = page * COLS + op.col_x;
                    mask = 8'h80 >> op.row_y[2:0];
                    if (op.pixel_on)
                        shadow_fb[idx] = shadow_fb[idx] | mask;
                    else
                        shadow_fb[idx] = shadow_fb[idx] & ~mask;
                    owe_status(mlfr_pkg::ST_OK);
                end
            end
            mlfr_pkg::ACT_FILL: begin
                for (int i = 0; i < PAGES_N * COLS; i++)
                    shadow_fb[i] = op.pixel_on ? mlfr_pkg::BYTE_BLACK : mlfr_pkg::BYTE_WHITE;
                owe_status(mlfr_pkg::ST_OK);
            end
            mlfr_pkg::ACT_CONTRAST: begin
                c = (op.contrast_pct > mlfr_pkg::PCT_MAX) ? int'(mlfr_pkg::PCT_MAX)
                                                          : int'(op.contrast_pct);
                c = c * VOL_FULL / int'(mlfr_pkg::PCT_MAX);
                owe_link(mlfr_pkg::CMD_VOLUME, 1'b1, 1'b0);
                owe_link(8'(c), 1'b1, 1'b1);
            end
            default: begin
                scan_on   = 1'b1;
                scan_page = 0;
                scan_step = 0;
                owe_status(mlfr_pkg::ST_OK);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: hold an op until it transfers, idle now and then
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                apply_lcd_op(driven_op);
            if (!in_bus.valid || in_bus.ready) begin
                if (op_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    driven_op = op_q.pop_front();
                    in_bus.action       <= driven_op.action;
                    in_bus.col_x        <= driven_op.col_x;
                    in_bus.row_y        <= driven_op.row_y;
                    in_bus.pixel_on     <= driven_op.pixel_on;
                    in_bus.contrast_pct <= driven_op.contrast_pct;
                    in_bus.valid        <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each output transfer against the oldest owed output
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got_out.out_kind    = out_bus.out_kind;
                got_out.status_code = out_bus.status_code;
                got_out.link_byte   = out_bus.link_byte;
                got_out.is_command  = out_bus.is_command;
                got_out.last_byte   = out_bus.last_byte;
                if (due_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected output, expected none", $time);
                    $display("%0t:   actual   kind=%0d code=%0d byte=%02h cmd=%0d last=%0d",
                             $time, got_out.out_kind, got_out.status_code,
                             got_out.link_byte, got_out.is_command, got_out.last_byte);
                end else begin
                    want_out = due_q.pop_front();
                    if (got_out.out_kind !== want_out.out_kind
                            || got_out.status_code !== want_out.status_code
                            || got_out.link_byte !== want_out.link_byte
                            || got_out.is_command !== want_out.is_command
                            || got_out.last_byte !== want_out.last_byte) begin
                        err_count++;
                        $display("%0t: mismatch, expected kind=%0d code=%0d byte=%02h cmd=%0d last=%0d",
                                 $time, want_out.out_kind, want_out.status_code,
                                 want_out.link_byte, want_out.is_command,
                                 want_out.last_byte);
                        $display("%0t:   actual   kind=%0d code=%0d byte=%02h cmd=%0d last=%0d",
                                 $time, got_out.out_kind, got_out.status_code,
                                 got_out.link_byte, got_out.is_command, got_out.last_byte);
                    end
                end
                outs_seen++;
                // Hold off once for a long stretch so the block backs up into its input
                if (outs_seen == STALL_AT)
                    stall_left = STALL_CYC;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            wdog_cnt = 0;
        else
            wdog_cnt++;
        if (wdog_cnt >= WDOG_LIMIT) begin
            $display("mono_lcd_framebuffer_refresher_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_op(input logic [2:0] act, input logic [7:0] x, input logic [7:0] y,
                           input logic on, input logic [7:0] pct);
        t_lcd_op op;
        op.action       = act;
        op.col_x        = x;
        op.row_y        = y;
        op.pixel_on     = on;
        op.contrast_pct = pct;
        op_q.push_back(op);
    endtask

    // Push an op of the given action with random content in every other field
    task automatic push_noisy(input logic [2:0] act);
        push_op(act, 8'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
    endtask

    // Wait until every op has transferred and every owed output has come
    task automatic wait_drained;
        do
            @(negedge i_clk);
        while (op_q.size() != 0 || in_bus.valid || due_q.size() != 0);
    endtask

    // Finish any refresh still running, then drain
    task automatic close_phase;
        wait_drained();
        while (scan_on) begin
            push_noisy(mlfr_pkg::ACT_TICK);
            wait_drained();
        end
    endtask

    // Let the block go quiet, write both panel registers, then set the calm flag
    task automatic start_phase(input logic [7:0] w, input logic [6:0] h, input bit quiet);
        repeat (SETTLE_CYC) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= mlfr_pkg::CFG_WIDTH;
        cfg_data <= w;
        @(posedge i_clk);
        cfg_width = w;
        cfg_idx  <= mlfr_pkg::CFG_HEIGHT;
        cfg_data <= {1'b0, h};
        @(posedge i_clk);
        cfg_height = h;
        cfg_we   <= 1'b0;
        calm = quiet;
        @(negedge i_clk);
    endtask

    // Refresh, then the given number of ticks, with the odd busy or ignored op mixed in
    task automatic push_stream(input int ticks);
        push_noisy(mlfr_pkg::ACT_REFRESH);
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    push_noisy(3'($urandom_range(mlfr_pkg::ACT_PIXEL, mlfr_pkg::ACT_REFRESH)));
                else
                    push_noisy(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
            end
            push_noisy(mlfr_pkg::ACT_TICK);
        end
    endtask

    // Random part of a phase: mostly well-formed bursts, some noise
    task automatic gen_random(input int budget);
        int weff;
        int hv;
        int len;
        int cut;
        int n;
        int pick;
        weff = (cfg_width < COLS) ? cfg_width : COLS;
        hv   = (cfg_height < PAGES_N * 8) ? cfg_height : PAGES_N * 8;
        len  = PAGES_N * (mlfr_pkg::HEAD_STEPS + weff);
        while (budget > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    if (weff > 0 && $urandom_range(0, 4) != 0)
                        push_op(mlfr_pkg::ACT_PIXEL, 8'($urandom_range(0, weff - 1)),
                                8'($urandom_range(0, hv - 1)), 1'($urandom), 8'($urandom));
                    else
                        push_noisy(mlfr_pkg::ACT_PIXEL);
                end
                budget -= n;
            end else if (pick < 60 && len <= budget) begin
                // Cut a stream short now and then; the drain at phase end finishes it
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
                push_stream(cut);
                budget -= cut + 1;
            end else if (pick < 75) begin
                push_noisy(mlfr_pkg::ACT_CONTRAST);
                budget--;
            end else if (pick < 78) begin
                push_noisy(mlfr_pkg::ACT_FILL);
                budget--;
            end else if (pick < 88) begin
                // Ignored ops: spare codes and ticks that may find no stream
                if ($urandom_range(0, 1) == 0)
                    push_noisy(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)));
                else
                    push_noisy(mlfr_pkg::ACT_TICK);
            end else begin
                push_noisy(mlfr_pkg::ACT_PIXEL);
                budget--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = mlfr_pkg::CFG_WIDTH;
        cfg_data = 8'd0;
        in_bus.valid        = 1'b0;
        in_bus.action       = mlfr_pkg::ACT_TICK;
        in_bus.col_x        = 8'd0;
        in_bus.row_y        = 8'd0;
        in_bus.pixel_on     = 1'b0;
        in_bus.contrast_pct = 8'd0;
        out_bus.ready       = 1'b0;
        for (int i = 0; i < PAGES_N * COLS; i++)
            shadow_fb[i] = 8'h00;
        scan_on    = 1'b0;
        scan_page  = 0;
        scan_step  = 0;
        cfg_width  = 8'd128;
        cfg_height = 7'd64;
        calm       = 1'b0;
        err_count  = 0;
        outs_seen  = 0;
        stall_left = 0;
        wdog_cnt   = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full panel: field extremes, contrast clamp, both fills, ignored ops
        start_phase(8'd128, 7'd64, 1'b0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd0, 8'd0, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd127, 8'd63, 1'b1, 8'd255);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd128, 8'd0, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd0, 8'd64, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd255, 8'd255, 1'b0, 8'd255);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd127, 8'd63, 1'b0, 8'd0);
        push_op(mlfr_pkg::ACT_CONTRAST, 8'd0, 8'd0, 1'b0, 8'd0);
        push_op(mlfr_pkg::ACT_CONTRAST, 8'd0, 8'd0, 1'b0, 8'd100);
        push_op(mlfr_pkg::ACT_CONTRAST, 8'd255, 8'd255, 1'b1, 8'd255);
        push_op(mlfr_pkg::ACT_CONTRAST, 8'd0, 8'd0, 1'b0, 8'd63);
        push_op(mlfr_pkg::ACT_FILL, 8'd0, 8'd0, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd5, 8'd9, 1'b0, 8'd0);
        push_op(mlfr_pkg::ACT_FILL, 8'd255, 8'd255, 1'b0, 8'd255);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd5, 8'd9, 1'b0, 8'd0);
        push_op(ACT_SPARE_LO, 8'd255, 8'd255, 1'b1, 8'd255);
        push_op(ACT_SPARE_HI, 8'd0, 8'd0, 1'b0, 8'd0);
        push_op(mlfr_pkg::ACT_TICK, 8'd0, 8'd0, 1'b0, 8'd0);
        gen_random(40);
        close_phase();

        // Zero width: every pixel is out of range, stream is commands only.
        // Hit each busy answer while the stream is armed.
        start_phase(8'd0, 7'd127, 1'b0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd0, 8'd0, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_REFRESH, 8'd0, 8'd0, 1'b0, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd0, 8'd0, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_FILL, 8'd0, 8'd0, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_CONTRAST, 8'd0, 8'd0, 1'b0, 8'd50);
        push_op(mlfr_pkg::ACT_REFRESH, 8'd0, 8'd0, 1'b0, 8'd0);
        gen_random(40);
        close_phase();

        // Width past the store clamps to the store
        start_phase(8'd200, 7'd64, 1'b0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd127, 8'd63, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd128, 8'd10, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd10, 8'd64, 1'b1, 8'd0);
        gen_random(30);
        close_phase();

        // Smallest panel, no idling on either side
        start_phase(8'd1, 7'd8, 1'b1);
        gen_random(100);
        close_phase();

        start_phase(8'd5, 7'd20, 1'b0);
        gen_random(100);
        close_phase();

        start_phase(8'($urandom_range(1, 16)), 7'($urandom_range(8, 64)), 1'b0);
        gen_random(100);
        close_phase();

        // Height past the store: rows of page 8 and up are out of range
        start_phase(8'd17, 7'd127, 1'b0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd3, 8'd64, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd16, 8'd63, 1'b1, 8'd0);
        push_op(mlfr_pkg::ACT_PIXEL, 8'd17, 8'd0, 1'b1, 8'd0);
        gen_random(80);
        close_phase();

        // Widest register value, then one full stream of the whole store
        start_phase(8'd255, 7'd127, 1'b0);
        gen_random(60);
        push_stream(PAGES_N * (mlfr_pkg::HEAD_STEPS + COLS));
        close_phase();

        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_count == 0 && due_q.size() == 0)
            $display("mono_lcd_framebuffer_refresher_unit verification clean");
        else
            $display("mono_lcd_framebuffer_refresher_unit verification failed");
        $finish;
    end

endmodule

/* mono_lcd_framebuffer_refresher_unit.f */
rtl/mlfr_pkg.sv
rtl/mlfr_in_if.sv
rtl/mlfr_out_if.sv
rtl/mlfr_ram.sv
rtl/mlfr_ctrl.sv
rtl/mlfr_datapath.sv
rtl/mono_lcd_framebuffer_refresher_unit.sv
tb/tb_mono_lcd_framebuffer_refresher_unit.sv
